// File: hw/rtl/ehd_pkg.sv
package ehd_pkg;

    // Directory geometry.
    localparam int MAX_DEPTH   = 10;
    localparam int BUCKET_BITS = 16;
    localparam int ADDR_W      = MAX_DEPTH;
    localparam int TABLE_SIZE  = 1 << MAX_DEPTH;
    localparam int CNT_W       = MAX_DEPTH + 1;

    // Field widths of the two channels.
    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 10;
    localparam int BADDR_W  = 16;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = 4;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DOUBLE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_HALVE  = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [SLOT_W-1:0]  slot_index;
        logic [BADDR_W-1:0] bucket_address;
    } ehd_in_t;

    typedef struct packed {
        logic [BADDR_W-1:0]  read_address;
        logic [STATUS_W-1:0] status;
        logic [DEPTH_W-1:0]  current_depth;
    } ehd_out_t;

endpackage

// File: hw/rtl/ehd_ram.sv
module ehd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and two registered read ports.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: hw/rtl/extendible_hash_directory.sv
// Channel   Ports                        Payload     Direction
// input     s_valid, s_ready, s_payload  ehd_in_t    operation request in
// result    m_valid, m_ready, m_payload  ehd_out_t   one result per request out
//
// Set, a get past the directory and a refused depth change are answered from the idle state; a
// get in range waits for one registered read of the slot RAM. Double copies each slot to its
// upper copy and halve compares each upper slot with its lower buddy, one slot pair going through
// the RAM ports each cycle; then the last read drains and the result is posted.
// After reset a clearing pass writes zero to all 2^MAX_DEPTH slots, one per
// cycle, before the first request is taken. A stalled result holds the block.
module extendible_hash_directory
    import ehd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ehd_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output ehd_out_t m_payload
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_GET   = 3'd2;
    localparam logic [2:0] ST_DBL   = 3'd3;
    localparam logic [2:0] ST_HLV   = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  prev_reg, prev_next;
    logic               pend_reg, pend_next;
    logic               mism_reg, mism_next;
    logic               m_valid_reg, m_valid_next;
    ehd_out_t           out_reg, out_next;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [BUCKET_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr_a, ram_raddr_b;
    logic [BUCKET_BITS-1:0] ram_rdata_a, ram_rdata_b;

    logic               accept;
    logic               in_range;
    logic [CNT_W-1:0]   size_w, half_w;

    ehd_ram #(
        .WIDTH(BUCKET_BITS),
        .DEPTH(TABLE_SIZE)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    // A new request is taken only in the idle state and when the result register is free or drains now.
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    // Directory size, the size of its lower half and the slot range check.
    assign size_w   = CNT_W'(1) << depth_reg;
    assign half_w   = size_w >> 1;
    assign in_range = ((s_payload.slot_index >> depth_reg) == '0) &&
                      ((s_payload.slot_index >> MAX_DEPTH) == '0);

    // Sequencer, RAM port control and result formation.
    always_comb begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        cnt_next     = cnt_reg;
        prev_next    = prev_reg;
        pend_next    = 1'b0;
        mism_next    = mism_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_we       = 1'b0;
        ram_waddr    = prev_reg;
        ram_wdata    = ram_rdata_a;
        ram_raddr_a  = cnt_reg[ADDR_W-1:0];
        ram_raddr_b  = half_w[ADDR_W-1:0] | cnt_reg[ADDR_W-1:0];

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[ADDR_W-1:0];
                ram_wdata = '0;
                if (cnt_reg == CNT_W'(TABLE_SIZE - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE: begin
                ram_raddr_a = s_payload.slot_index[ADDR_W-1:0];
                if (accept) begin
                    out_next.read_address  = '0;
                    out_next.status        = STATUS_OK;
                    out_next.current_depth = depth_reg;
                    cnt_next  = '0;
                    mism_next = 1'b0;
                    case (s_payload.func)
                        FUNC_GET: begin
                            if (in_range) begin
                                state_next = ST_GET;
                            end else begin
                                out_next.status = STATUS_RANGE;
                                m_valid_next    = 1'b1;
                            end
                        end
                        FUNC_SET: begin
                            ram_we       = in_range;
                            ram_waddr    = s_payload.slot_index[ADDR_W-1:0];
                            ram_wdata    = BUCKET_BITS'(s_payload.bucket_address);
                            m_valid_next = 1'b1;
                        end
                        FUNC_DOUBLE: begin
                            if (depth_reg >= DEPTH_W'(MAX_DEPTH)) begin
                                out_next.status = STATUS_REFUSED;
                                m_valid_next    = 1'b1;
                            end else begin
                                state_next = ST_DBL;
                            end
                        end
                        default: begin
                            if (depth_reg <= DEPTH_W'(1)) begin
                                out_next.status = STATUS_REFUSED;
                                m_valid_next    = 1'b1;
                            end else begin
                                state_next = ST_HLV;
                            end
                        end
                    endcase
                end
            end
            ST_GET: begin
                out_next.read_address = BADDR_W'(ram_rdata_a);
                m_valid_next          = 1'b1;
                state_next            = ST_IDLE;
            end
            ST_DBL: begin
                // Read slot i while the slot read last cycle lands in its upper copy.
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = size_w[ADDR_W-1:0] | prev_reg;
                    ram_wdata = ram_rdata_a;
                end
                if (cnt_reg < size_w) begin
                    pend_next = 1'b1;
                    prev_next = cnt_reg[ADDR_W-1:0];
                    cnt_next  = cnt_reg + CNT_W'(1);
                end else if (!pend_reg) begin
                    depth_next             = depth_reg + DEPTH_W'(1);
                    out_next.current_depth = depth_reg + DEPTH_W'(1);
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            ST_HLV: begin
                // Compare each upper slot with its lower buddy, one pair a cycle.
                if (pend_reg && (ram_rdata_a != ram_rdata_b)) begin
                    mism_next = 1'b1;
                end
                if (cnt_reg < half_w) begin
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end else if (!pend_reg) begin
                    if (mism_reg) begin
                        out_next.status = STATUS_REFUSED;
                    end else begin
                        depth_next             = depth_reg - DEPTH_W'(1);
                        out_next.current_depth = depth_reg - DEPTH_W'(1);
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state is reset; the result payload and scratch index are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            depth_reg   <= DEPTH_W'(1);
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            mism_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            mism_reg    <= mism_next;
            m_valid_reg <= m_valid_next;
        end
        prev_reg <= prev_next;
        out_reg  <= out_next;
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ehd_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int REPORT_MAX  = 10;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    ehd_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    ehd_out_t m_payload;

    // Shadow copy of the directory, advanced once per accepted transaction.
    logic [DEPTH_W-1:0]     dir_depth;
    logic [BUCKET_BITS-1:0] dir_slots [TABLE_SIZE];

    ehd_out_t pending_results [$];
    int       error_count = 0;
    int       cycle_count = 0;
    bit       no_idle     = 1'b0;

    extendible_hash_directory uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one operation to the shadow directory and returns its result.
    function automatic ehd_out_t apply_dir_op(ehd_in_t op);
        ehd_out_t res;
        int       size;
        int       half;
        bit       ok;
        res = '0;
        res.status = STATUS_OK;
        size = 1 << dir_depth;
        case (op.func)
            FUNC_GET: begin
                if (int'(op.slot_index) < size) begin
                    res.read_address = dir_slots[op.slot_index];
                end else begin
                    res.status = STATUS_RANGE;
                end
            end
            FUNC_SET: begin
                if (int'(op.slot_index) < size) begin
                    dir_slots[op.slot_index] = op.bucket_address;
                end
            end
            FUNC_DOUBLE: begin
                if (dir_depth >= MAX_DEPTH) begin
                    res.status = STATUS_REFUSED;
                end else begin
                    for (int i = 0; i < size; i++) begin
                        dir_slots[size | i] = dir_slots[i];
                    end
                    dir_depth = dir_depth + 1'b1;
                end
            end
            default: begin
                ok = (dir_depth > 1);
                half = size >> 1;
                for (int i = 0; ok && i < half; i++) begin
                    if (dir_slots[half | i] != dir_slots[i]) begin
                        ok = 1'b0;
                    end
                end
                if (ok) begin
                    dir_depth = dir_depth - 1'b1;
                end else begin
                    res.status = STATUS_REFUSED;
                end
            end
        endcase
        res.current_depth = dir_depth;
        return res;
    endfunction

    function automatic ehd_in_t make_op(logic [FUNC_W-1:0] func, int idx, int addr);
        ehd_in_t op;
        op.func           = func;
        op.slot_index     = idx[SLOT_W-1:0];
        op.bucket_address = addr[BADDR_W-1:0];
        return op;
    endfunction

    // Presents one transaction, holds it until accepted, then records its expected result.
    task automatic send_op(ehd_in_t op);
        if (!no_idle && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(apply_dir_op(op));
    endtask

    // The result side stalls at random, except during the no-idle stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 16);
        end
    end

    // Compares every accepted result with the oldest expectation.
    always @(posedge aclk) begin : check_result
        ehd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX) begin
                    $display("unexpected result: addr=%h status=%0d depth=%0d",
                             m_payload.read_address, m_payload.status,
                             m_payload.current_depth);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_payload.read_address !== want.read_address ||
                    m_payload.status !== want.status ||
                    m_payload.current_depth !== want.current_depth) begin
                    error_count++;
                    if (error_count <= REPORT_MAX) begin
                        $display("mismatch: expected addr=%h status=%0d depth=%0d, got addr=%h status=%0d depth=%0d",
                                 want.read_address, want.status, want.current_depth,
                                 m_payload.read_address, m_payload.status,
                                 m_payload.current_depth);
                    end
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** extendible_hash_directory: FAILED **");
            $finish;
        end
    end

    // Directory starts cleared at depth one; out-of-range get and halve at depth one.
    task automatic test_reset_state();
        send_op(make_op(FUNC_GET, 0, 0));
        send_op(make_op(FUNC_GET, 1, 16'hFFFF));
        send_op(make_op(FUNC_GET, 1023, 0));
        send_op(make_op(FUNC_HALVE, 0, 0));
    endtask

    // Writes inside and past the directory, with all-ones and alternating data, then reads slots back.
    task automatic test_slot_range();
        send_op(make_op(FUNC_SET, 1, 16'hFFFF));
        send_op(make_op(FUNC_SET, 2, 16'h1234));
        send_op(make_op(FUNC_SET, 1023, 16'hFFFF));
        send_op(make_op(FUNC_SET, 0, 16'hA5A5));
        send_op(make_op(FUNC_GET, 1, 0));
        send_op(make_op(FUNC_GET, 2, 0));
        send_op(make_op(FUNC_GET, 0, 0));
    endtask

    // Grows to full depth, refuses one more double, then halves with a broken and a restored buddy.
    task automatic test_depth_limits();
        for (int i = 1; i < MAX_DEPTH; i++) begin
            send_op(make_op(FUNC_DOUBLE, 0, 0));
        end
        send_op(make_op(FUNC_DOUBLE, 0, 0));
        send_op(make_op(FUNC_SET, 1023, 16'h5A5A));
        send_op(make_op(FUNC_GET, 1023, 0));
        send_op(make_op(FUNC_HALVE, 0, 0));
        send_op(make_op(FUNC_SET, 1023, int'(dir_slots[511])));
        send_op(make_op(FUNC_HALVE, 0, 0));
        send_op(make_op(FUNC_GET, 1023, 0));
    endtask

    // Mixed traffic. Most halves are preceded by sets that restore buddy symmetry.
    task automatic test_random_traffic();
        int      pick;
        int      size;
        int      half;
        int      idx;
        int      addr;
        for (int n = 0; n < 400; n++) begin
            no_idle = (n >= 150 && n < 250);
            pick = $urandom_range(99);
            size = 1 << dir_depth;
            idx = ($urandom_range(99) < 85) ? $urandom_range(size - 1) : $urandom_range(1023);
            case ($urandom_range(3))
                0: addr = 0;
                1: addr = 16'hFFFF;
                default: addr = $urandom_range(16'hFFFF);
            endcase
            if (pick < 38) begin
                send_op(make_op(FUNC_GET, idx, addr));
            end else if (pick < 72) begin
                send_op(make_op(FUNC_SET, idx, addr));
            end else if (dir_depth < 4 || $urandom_range(9) == 0) begin
                send_op(make_op(FUNC_DOUBLE, idx, addr));
            end else begin
                if ($urandom_range(3) != 0) begin
                    half = size >> 1;
                    for (int i = 0; i < half; i++) begin
                        if (dir_slots[half | i] != dir_slots[i]) begin
                            send_op(make_op(FUNC_SET, half | i, int'(dir_slots[i])));
                        end
                    end
                end
                send_op(make_op(FUNC_HALVE, idx, addr));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        dir_depth = 1;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            dir_slots[i] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_slot_range();
        test_depth_limits();
        test_random_traffic();
        s_valid <= 1'b0;

        // Drain outstanding results, then allow a short settling window.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("** extendible_hash_directory: PASSED **");
        end else begin
            $display("** extendible_hash_directory: FAILED **");
        end
        $finish;
    end

endmodule

// File: extendible_hash_directory.f
hw/rtl/ehd_pkg.sv
hw/rtl/ehd_ram.sv
hw/rtl/extendible_hash_directory.sv
tb/testbench.sv
